// File: design/tlpfa_pkg.sv
// ----------------------------------------------------------------------------
// tlpfa_pkg
// Shared types, constants and helper functions of the two-level page frame
// allocator: record layouts of the frame memories, status codes and the
// reference count arithmetic.
// ----------------------------------------------------------------------------
package tlpfa_pkg;

	localparam int LARGE_FRAMES    = 64;
	localparam int SMALL_PER_LARGE = 512;
	localparam int REF_BITS        = 32;

	localparam int LIDX_W = $clog2(LARGE_FRAMES);
	localparam int LPTR_W = $clog2(LARGE_FRAMES + 1);
	localparam int SIDX_W = $clog2(SMALL_PER_LARGE);
	localparam int SCNT_W = SIDX_W + 1;
	localparam int REF_W  = 32;
	localparam int ADDR_W = 48;
	localparam int BASE_W = 27;
	localparam int NCFG_W = 7;
	localparam int PAGE_SHIFT = 12;

	localparam logic [LPTR_W-1:0] LNULL     = LPTR_W'(LARGE_FRAMES);
	localparam logic [REF_W-1:0]  REF_MAX   = REF_W'((64'(1) << REF_BITS) - 64'(1));
	localparam logic [SCNT_W-1:0] SLOTS_ALL = SCNT_W'(SMALL_PER_LARGE - 1);

	// Configuration register indexes.
	localparam logic CFG_BASE  = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		REQ_ALLOC_SMALL = 2'd0,
		REQ_ALLOC_LARGE = 2'd1,
		REQ_RELEASE     = 2'd2,
		REQ_BAD         = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		RS_OK        = 3'd0,
		RS_RANGE     = 3'd1,
		RS_FREE      = 3'd2,
		RS_RESERVED  = 3'd3,
		RS_IN_USE    = 3'd4,
		RS_NO_MEMORY = 3'd5,
		RS_INTEGRITY = 3'd6
	} resp_t;

	typedef enum logic [2:0] {
		LS_FREE  = 3'd0,
		LS_USED  = 3'd1,
		LS_SPLIT = 3'd2,
		LS_FULL  = 3'd3,
		LS_RESV  = 3'd4
	} lstat_t;

	typedef enum logic [1:0] {
		SS_FREE = 2'd0,
		SS_USED = 2'd1
	} sstat_t;

	typedef struct packed {
		lstat_t              st;
		logic [LPTR_W-1:0]   nxt;
		logic [LPTR_W-1:0]   prv;
		logic [REF_W-1:0]    refs;
		logic [SIDX_W-1:0]   shead;
		logic [SCNT_W-1:0]   scnt;
	} lrec_t;

	typedef struct packed {
		sstat_t              st;
		logic [SIDX_W-1:0]   nxt;
		logic [REF_W-1:0]    refs;
	} srec_t;

	typedef struct packed {
		logic             free;
		logic [REF_W-1:0] val;
	} ct_t;

	function automatic logic [REF_W-1:0] sat_count(input logic [REF_W-1:0] cnt);
		return (cnt > REF_MAX) ? REF_MAX : cnt;
	endfunction

	// Applies a signed count change with saturation; a zero change is a plain
	// release test.
	function automatic ct_t count_test(input logic [REF_W-1:0] refs,
			input logic signed [31:0] delta, input logic ign);
		ct_t r;
		logic signed [REF_W+1:0] v;
		v = $signed({2'b00, refs}) + (REF_W+2)'(delta);
		if (delta == 32'sd0) begin
			r.free = ign || (refs <= REF_W'(1));
			r.val  = refs;
		end else begin
			if (v < 0)
				r.val = '0;
			else if (v > $signed({2'b00, REF_MAX}))
				r.val = REF_MAX;
			else
				r.val = v[REF_W-1:0];
			r.free = (r.val == '0);
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] frame_address(input logic [BASE_W-1:0] base,
			input logic [LIDX_W-1:0] l, input logic [SIDX_W-1:0] s);
		logic [BASE_W-1:0] sum;
		sum = base + BASE_W'(l);
		return {sum, s, PAGE_SHIFT'(0)};
	endfunction

endpackage

// File: design/tlpfa_ram.sv
// ----------------------------------------------------------------------------
// tlpfa_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only when read enable is high.
// ----------------------------------------------------------------------------
module tlpfa_ram #(
	parameter int W = 8,
	parameter int D = 64,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: design/two_level_page_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// two_level_page_frame_allocator_core
// Allocator of 2 MiB frames and of 4 KiB frames carved out of split 2 MiB
// frames, with per-frame reference counts, built around two frame memories.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the input channel (in_valid/in_ready) as req_type,
// frame_addr, ref_count, ref_delta and ignore_refs. Each request produces
// exactly one result on the output channel (out_valid/out_ready) carrying
// result_addr, status and new_ref_count. The block works on one request at a
// time: a request is taken only in the idle state, and every step of it is a
// read of the frame memory followed by a write back. The time from input
// transfer to result valid is set by the number of dependent read-modify-write
// steps on the large frame memory, including list pointer repairs of neighbor
// frames (a read and a write back per repaired neighbor). A 4 KiB allocation
// that has to split a fresh 2 MiB frame writes all 512 slot records of the
// small frame memory, one per cycle. The next request is taken the cycle after
// a result has moved into the output register.
// After reset, and after any configuration write, the block runs a pass that
// rebuilds the free stack of large frames; no request is taken meanwhile. A
// finished result waits in an output register; while the receiver stalls, the
// next request can still be taken and worked on, and it waits for the output
// register to drain before it completes.
// ----------------------------------------------------------------------------
module two_level_page_frame_allocator_core import tlpfa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               req_type,
	input  logic [ADDR_W-1:0]        frame_addr,
	input  logic [REF_W-1:0]         ref_count,
	input  logic signed [31:0]       ref_delta,
	input  logic                     ignore_refs,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ADDR_W-1:0]        result_addr,
	output logic [2:0]               status,
	output logic [REF_W-1:0]         new_ref_count,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [BASE_W-1:0]        cfg_wdata
);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DISP, S_AS_RD, S_AS_SRD, S_ALG, S_AL_RD, S_SPLIT,
		S_FIX_RD, S_FIX_WR, S_R_RD, S_R_SRD, S_RESP
	} state_t;

	localparam int SADDR_W = LIDX_W + SIDX_W;

	state_t state_q;

	// Configuration and list heads.
	logic [BASE_W-1:0] base_q;
	logic [NCFG_W-1:0] nin_q;
	logic [LPTR_W-1:0] lfree_q;
	logic [LPTR_W-1:0] shead_q;
	logic [LPTR_W-1:0] nframes;

	// Request held for the duration of the operation.
	req_t              type_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [REF_W-1:0]  cnt_q;
	logic signed [31:0] delta_q;
	logic              ign_q;

	logic [LIDX_W-1:0] fr_q;       // frame being worked on
	logic [SIDX_W-1:0] sl_q;       // slot being worked on
	logic [SIDX_W-1:0] sweep_q;    // slot counter of the split pass
	logic [LIDX_W-1:0] ini_q;      // frame counter of the init pass
	logic              after_alg_q;

	// Pending pointer repairs: prev field of one frame, next field of another.
	logic              pf_v_q, nf_v_q, fsel_q;
	logic [LIDX_W-1:0] pf_a_q, nf_a_q, fx_a_q;
	logic [LPTR_W-1:0] pf_d_q, nf_d_q;

	// Result being built and the output register.
	logic [ADDR_W-1:0] res_addr_q;
	resp_t             res_st_q;
	logic [REF_W-1:0]  res_newc_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [2:0]        out_st_q;
	logic [REF_W-1:0]  out_newc_q;

	// Memory ports.
	logic                 lre, lwe, sre, swe;
	logic [LIDX_W-1:0]    lraddr, lwaddr;
	lrec_t                lwdata, lrd;
	logic [$bits(lrec_t)-1:0] lrd_raw;
	logic [SADDR_W-1:0]   sraddr, swaddr;
	srec_t                swdata, srd;
	logic [$bits(srec_t)-1:0] srd_raw;

	assign lrd = lrec_t'(lrd_raw);
	assign srd = srec_t'(srd_raw);

	tlpfa_ram #(.W($bits(lrec_t)), .D(LARGE_FRAMES)) u_large_mem (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.re    (lre),
		.raddr (lraddr),
		.rdata (lrd_raw)
	);

	tlpfa_ram #(.W($bits(srec_t)), .D(LARGE_FRAMES * SMALL_PER_LARGE)) u_small_mem (
		.clk   (clk),
		.we    (swe),
		.waddr (swaddr),
		.wdata (swdata),
		.re    (sre),
		.raddr (sraddr),
		.rdata (srd_raw)
	);

	// Decoded request and shared arithmetic.
	logic [BASE_W-1:0] a_frame;
	logic [BASE_W:0]   area_end;
	logic              in_range;
	logic [LIDX_W-1:0] rel_l;
	logic [SIDX_W-1:0] rel_s;
	ct_t               ct_l, ct_s;
	logic              delta_nz;
	logic [SCNT_W-1:0] scnt_inc;
	logic [LIDX_W-1:0] ini_next;
	logic              ini_last;
	logic              sweep_last;
	logic              out_free;

	assign nframes  = (32'(nin_q) > LARGE_FRAMES) ? LNULL : LPTR_W'(nin_q);
	assign a_frame  = faddr_q[ADDR_W-1 -: BASE_W];
	assign area_end = {1'b0, base_q} + (BASE_W+1)'(nframes);
	assign in_range = (a_frame >= base_q) && ({1'b0, a_frame} < area_end);
	assign rel_l    = LIDX_W'(a_frame - base_q);
	assign rel_s    = faddr_q[PAGE_SHIFT +: SIDX_W];
	assign ct_l     = count_test(lrd.refs, delta_q, ign_q);
	assign ct_s     = count_test(srd.refs, delta_q, ign_q);
	assign delta_nz = (delta_q != 32'sd0);
	assign scnt_inc = lrd.scnt + SCNT_W'(1);
	assign ini_next = ini_q + LIDX_W'(1);
	assign ini_last = (ini_q == LIDX_W'(LARGE_FRAMES - 1));
	assign sweep_last = (sweep_q == SIDX_W'(SMALL_PER_LARGE - 1));
	assign out_free = !out_valid_q || out_ready;

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign result_addr   = out_addr_q;
	assign status        = out_st_q;
	assign new_ref_count = out_newc_q;

	// Memory port control: one read and one write per memory per cycle.
	always_comb begin
		lre    = 1'b0;
		lraddr = fr_q;
		lwe    = 1'b0;
		lwaddr = fr_q;
		lwdata = lrd;
		sre    = 1'b0;
		sraddr = {fr_q, sl_q};
		swe    = 1'b0;
		swaddr = {fr_q, sweep_q};
		swdata = srd;
		unique case (state_q)
			S_INIT: begin
				lwe         = 1'b1;
				lwaddr      = ini_q;
				lwdata      = '0;
				lwdata.st   = (LPTR_W'(ini_q) < nframes) ? LS_FREE : LS_RESV;
				lwdata.nxt  = ((LPTR_W+1)'(ini_q) + (LPTR_W+1)'(1) < (LPTR_W+1)'(nframes))
					? LPTR_W'(ini_next) : LNULL;
				lwdata.prv  = LNULL;
			end
			S_DISP: begin
				if (type_q == REQ_ALLOC_SMALL && shead_q != LNULL) begin
					lre    = 1'b1;
					lraddr = LIDX_W'(shead_q);
				end else if (type_q == REQ_RELEASE && in_range) begin
					lre    = 1'b1;
					lraddr = rel_l;
				end
			end
			S_AS_RD: begin
				if (lrd.shead != '0) begin
					sre    = 1'b1;
					sraddr = {fr_q, lrd.shead};
				end else begin
					lwe       = 1'b1;
					lwdata.st = LS_FULL;
				end
			end
			S_AS_SRD: begin
				swe         = 1'b1;
				swaddr      = {fr_q, sl_q};
				swdata.st   = SS_USED;
				swdata.refs = sat_count(cnt_q);
				lwe          = 1'b1;
				lwdata.shead = srd.nxt;
				lwdata.scnt  = lrd.scnt - SCNT_W'(1);
				if (srd.nxt == '0)
					lwdata.st = LS_FULL;
			end
			S_ALG: begin
				if (lfree_q != LNULL) begin
					lre    = 1'b1;
					lraddr = LIDX_W'(lfree_q);
				end
			end
			S_AL_RD: begin
				if (type_q == REQ_ALLOC_LARGE) begin
					lwe         = 1'b1;
					lwdata.st   = LS_USED;
					lwdata.refs = sat_count(cnt_q);
				end
			end
			S_SPLIT: begin
				// Slot 0 is reserved, slot 1 goes straight to the requester and
				// the rest are chained in order on the free stack.
				swe = 1'b1;
				if (sweep_q == '0) begin
					swdata = '0;
				end else if (sweep_q == SIDX_W'(1)) begin
					swdata.st   = SS_USED;
					swdata.nxt  = SIDX_W'(2);
					swdata.refs = sat_count(cnt_q);
				end else begin
					swdata.st   = SS_FREE;
					swdata.nxt  = sweep_q + SIDX_W'(1);
					swdata.refs = '0;
				end
				if (sweep_last) begin
					lwe          = 1'b1;
					lwdata.st    = LS_SPLIT;
					lwdata.nxt   = shead_q;
					lwdata.prv   = LNULL;
					lwdata.shead = SIDX_W'(2);
					lwdata.scnt  = SLOTS_ALL - SCNT_W'(1);
				end
			end
			S_FIX_RD: begin
				lre    = pf_v_q || nf_v_q;
				lraddr = pf_v_q ? pf_a_q : nf_a_q;
			end
			S_FIX_WR: begin
				lwe    = 1'b1;
				lwaddr = fx_a_q;
				if (fsel_q)
					lwdata.nxt = nf_d_q;
				else
					lwdata.prv = pf_d_q;
			end
			S_R_RD: begin
				if (lrd.st == LS_USED) begin
					if (ct_l.free) begin
						lwe         = 1'b1;
						lwdata.st   = LS_FREE;
						lwdata.refs = '0;
						lwdata.nxt  = lfree_q;
					end else if (delta_nz) begin
						lwe         = 1'b1;
						lwdata.refs = ct_l.val;
					end
				end else if ((lrd.st == LS_SPLIT || lrd.st == LS_FULL) && sl_q != '0) begin
					sre    = 1'b1;
					sraddr = {fr_q, sl_q};
				end
			end
			S_R_SRD: begin
				swaddr = {fr_q, sl_q};
				if (srd.st == SS_USED) begin
					if (ct_s.free) begin
						swe          = 1'b1;
						swdata.st    = SS_FREE;
						swdata.nxt   = lrd.shead;
						swdata.refs  = ct_s.val;
						lwe          = 1'b1;
						lwdata.shead = sl_q;
						lwdata.scnt  = scnt_inc;
						if (lrd.st == LS_FULL) begin
							lwdata.st  = LS_SPLIT;
							lwdata.nxt = shead_q;
							lwdata.prv = LNULL;
						end else if (scnt_inc == SLOTS_ALL) begin
							// Every slot is free again: back to the large stack.
							lwdata.st   = LS_FREE;
							lwdata.refs = '0;
							lwdata.nxt  = lfree_q;
							lwdata.prv  = LNULL;
						end
					end else if (delta_nz) begin
						swe         = 1'b1;
						swdata.refs = ct_s.val;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer, list heads, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			base_q      <= '0;
			nin_q       <= NCFG_W'(64);
			lfree_q     <= '0;
			shead_q     <= LNULL;
			ini_q       <= '0;
			sweep_q     <= '0;
			pf_v_q      <= 1'b0;
			nf_v_q      <= 1'b0;
			fsel_q      <= 1'b0;
			after_alg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register loads a finished result or drains on a transfer.
			if (state_q == S_RESP && out_free && !cfg_we)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				// A configuration write rebuilds the frame area with the new values.
				unique case (cfg_index)
					CFG_BASE:  base_q <= cfg_wdata;
					CFG_COUNT: nin_q  <= cfg_wdata[NCFG_W-1:0];
				endcase
				ini_q   <= '0;
				state_q <= S_INIT;
			end else begin
				unique case (state_q)
					S_INIT: begin
						ini_q <= ini_next;
						if (ini_last) begin
							lfree_q <= (nframes != '0) ? '0 : LNULL;
							shead_q <= LNULL;
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (in_valid) begin
							type_q     <= req_t'(req_type);
							faddr_q    <= frame_addr;
							cnt_q      <= ref_count;
							delta_q    <= ref_delta;
							ign_q      <= ignore_refs;
							res_addr_q <= '0;
							res_newc_q <= '0;
							res_st_q   <= RS_OK;
							pf_v_q     <= 1'b0;
							nf_v_q     <= 1'b0;
							state_q    <= S_DISP;
						end
					end
					S_DISP: begin
						unique case (type_q)
							REQ_ALLOC_SMALL: begin
								if (shead_q != LNULL) begin
									fr_q    <= LIDX_W'(shead_q);
									state_q <= S_AS_RD;
								end else begin
									state_q <= S_ALG;
								end
							end
							REQ_ALLOC_LARGE: state_q <= S_ALG;
							REQ_RELEASE: begin
								fr_q <= rel_l;
								sl_q <= rel_s;
								if (in_range) begin
									state_q <= S_R_RD;
								end else begin
									res_st_q <= RS_RANGE;
									state_q  <= S_RESP;
								end
							end
							default: begin
								res_st_q <= RS_RANGE;
								state_q  <= S_RESP;
							end
						endcase
					end
					S_AS_RD: begin
						if (lrd.shead != '0) begin
							sl_q    <= lrd.shead;
							state_q <= S_AS_SRD;
						end else begin
							// Stale list head with no free slot: retire it and split.
							shead_q     <= lrd.nxt;
							pf_v_q      <= (lrd.nxt != LNULL);
							pf_a_q      <= LIDX_W'(lrd.nxt);
							pf_d_q      <= LNULL;
							after_alg_q <= 1'b1;
							state_q     <= S_FIX_RD;
						end
					end
					S_AS_SRD: begin
						res_addr_q <= frame_address(base_q, fr_q, sl_q);
						if (srd.nxt == '0) begin
							shead_q <= lrd.nxt;
							pf_v_q  <= (lrd.nxt != LNULL);
							pf_a_q  <= LIDX_W'(lrd.nxt);
							pf_d_q  <= LNULL;
						end
						after_alg_q <= 1'b0;
						state_q     <= S_FIX_RD;
					end
					S_ALG: begin
						if (lfree_q == LNULL) begin
							res_addr_q <= '0;
							res_st_q   <= RS_NO_MEMORY;
							state_q    <= S_RESP;
						end else begin
							fr_q    <= LIDX_W'(lfree_q);
							state_q <= S_AL_RD;
						end
					end
					S_AL_RD: begin
						lfree_q <= lrd.nxt;
						if (type_q == REQ_ALLOC_LARGE) begin
							res_addr_q <= frame_address(base_q, fr_q, '0);
							state_q    <= S_RESP;
						end else begin
							sweep_q <= '0;
							state_q <= S_SPLIT;
						end
					end
					S_SPLIT: begin
						sweep_q <= sweep_q + SIDX_W'(1);
						if (sweep_last) begin
							res_addr_q  <= frame_address(base_q, fr_q, SIDX_W'(1));
							pf_v_q      <= (shead_q != LNULL);
							pf_a_q      <= LIDX_W'(shead_q);
							pf_d_q      <= LPTR_W'(fr_q);
							shead_q     <= LPTR_W'(fr_q);
							after_alg_q <= 1'b0;
							state_q     <= S_FIX_RD;
						end
					end
					S_FIX_RD: begin
						if (pf_v_q) begin
							fx_a_q  <= pf_a_q;
							fsel_q  <= 1'b0;
							state_q <= S_FIX_WR;
						end else if (nf_v_q) begin
							fx_a_q  <= nf_a_q;
							fsel_q  <= 1'b1;
							state_q <= S_FIX_WR;
						end else begin
							state_q <= after_alg_q ? S_ALG : S_RESP;
						end
					end
					S_FIX_WR: begin
						if (fsel_q)
							nf_v_q <= 1'b0;
						else
							pf_v_q <= 1'b0;
						state_q <= S_FIX_RD;
					end
					S_R_RD: begin
						priority case (lrd.st)
							LS_FREE: begin
								res_st_q <= RS_FREE;
								state_q  <= S_RESP;
							end
							LS_RESV: begin
								res_st_q <= RS_RESERVED;
								state_q  <= S_RESP;
							end
							LS_USED: begin
								if (delta_nz)
									res_newc_q <= ct_l.val;
								if (ct_l.free) begin
									lfree_q  <= LPTR_W'(fr_q);
									res_st_q <= RS_OK;
								end else begin
									res_st_q <= delta_nz ? RS_OK : RS_IN_USE;
								end
								state_q <= S_RESP;
							end
							LS_SPLIT, LS_FULL: begin
								if (sl_q == '0) begin
									res_st_q <= RS_RESERVED;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_R_SRD;
								end
							end
							default: begin
								res_st_q <= RS_INTEGRITY;
								state_q  <= S_RESP;
							end
						endcase
					end
					S_R_SRD: begin
						after_alg_q <= 1'b0;
						priority if (srd.st == SS_FREE) begin
							res_st_q <= RS_FREE;
							state_q  <= S_RESP;
						end else if (srd.st != SS_USED) begin
							res_st_q <= RS_RESERVED;
							state_q  <= S_RESP;
						end else begin
							if (delta_nz)
								res_newc_q <= ct_s.val;
							if (!ct_s.free) begin
								res_st_q <= delta_nz ? RS_OK : RS_IN_USE;
								state_q  <= S_RESP;
							end else begin
								res_st_q <= RS_OK;
								state_q  <= S_FIX_RD;
								if (lrd.st == LS_FULL) begin
									// A full frame regains a slot: push it on the split list.
									pf_v_q  <= (shead_q != LNULL);
									pf_a_q  <= LIDX_W'(shead_q);
									pf_d_q  <= LPTR_W'(fr_q);
									shead_q <= LPTR_W'(fr_q);
								end else if (scnt_inc == SLOTS_ALL) begin
									// Unlink from the split list and return to the large stack.
									pf_v_q  <= (lrd.nxt != LNULL);
									pf_a_q  <= LIDX_W'(lrd.nxt);
									pf_d_q  <= lrd.prv;
									nf_v_q  <= (lrd.prv != LNULL);
									nf_a_q  <= LIDX_W'(lrd.prv);
									nf_d_q  <= lrd.nxt;
									if (shead_q == LPTR_W'(fr_q))
										shead_q <= lrd.nxt;
									lfree_q <= LPTR_W'(fr_q);
								end
							end
						end
					end
					S_RESP: begin
						if (out_free) begin
							out_addr_q  <= res_addr_q;
							out_st_q    <= res_st_q;
							out_newc_q  <= res_newc_q;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_INIT;
				endcase
			end
		end
	end

endmodule

// File: design/tlpfa_checker.sv
// ----------------------------------------------------------------------------
// tlpfa_checker
// Port-level checks of the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module tlpfa_checker import tlpfa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ADDR_W-1:0] result_addr,
	input logic [2:0]        status,
	input logic [REF_W-1:0]  new_ref_count
);

	// One request at a time: the input closes right after a transfer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted a second request while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("result carries an undefined status code");

	// A failed or refused request allocates nothing and reports no count.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(RS_OK) |-> result_addr == '0 && new_ref_count == '0)
		else $error("failed request returned an address or a count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
		else $error("stalled result changed or vanished");

endmodule

bind two_level_page_frame_allocator_core tlpfa_checker u_tlpfa_checker (.*);

// File: dv/tb_two_level_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_page_frame_allocator_core
// Self-checking bench for the two-level page frame allocator. A behavioral
// copy of the allocator state predicts every result. Requests and results
// move over valid/ready with random idling on both sides. The run walks
// through several area settings, including the widest base, a single frame
// that is filled to the last slot, an empty area and an oversized count.
// ----------------------------------------------------------------------------
module tb_two_level_page_frame_allocator_core;
	import tlpfa_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [1:0]        rtype;
		logic [ADDR_W-1:0] addr;
		logic [REF_W-1:0]  cnt;
		logic signed [31:0] delta;
		logic              ign;
		logic [ADDR_W-1:0] want_addr;
		logic [2:0]        want_status;
		logic [REF_W-1:0]  want_count;
	} request_s;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = '0;
	logic [ADDR_W-1:0] frame_addr = '0;
	logic [REF_W-1:0] ref_count = '0;
	logic signed [31:0] ref_delta = '0;
	logic ignore_refs = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ADDR_W-1:0] result_addr;
	logic [2:0] status;
	logic [REF_W-1:0] new_ref_count;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_BASE;
	logic [BASE_W-1:0] cfg_wdata = '0;

	// Requests waiting to be offered, and predicted results of those accepted.
	request_s waiting_reqs[$];
	request_s awaited_results[$];
	// Addresses currently handed out, used as targets for releases.
	logic [ADDR_W-1:0] live_frames[$];

	int errors = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_seq = 0;
	longint cycles = 0;

	// Shadow copy of the allocator state.
	logic [BASE_W-1:0] area_base;
	int unsigned area_count;
	lstat_t lg_state[LARGE_FRAMES];
	int unsigned lg_next[LARGE_FRAMES];
	int unsigned lg_prev[LARGE_FRAMES];
	logic [REF_W-1:0] lg_refs[LARGE_FRAMES];
	int unsigned sm_head[LARGE_FRAMES];
	int unsigned sm_count[LARGE_FRAMES];
	logic [1:0] sm_state[LARGE_FRAMES*SMALL_PER_LARGE];
	int unsigned sm_next[LARGE_FRAMES*SMALL_PER_LARGE];
	logic [REF_W-1:0] sm_refs[LARGE_FRAMES*SMALL_PER_LARGE];
	int unsigned free_stack_top;
	int unsigned split_top;

	two_level_page_frame_allocator_core dut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned frames_managed();
		return (area_count > LARGE_FRAMES) ? LARGE_FRAMES : area_count;
	endfunction

	// Rebuilds the free stack in index order; frames past the count are reserved.
	function automatic void rebuild_area();
		int unsigned n;
		n = frames_managed();
		for (int i = 0; i < LARGE_FRAMES; i++) begin
			lg_state[i] = (i < n) ? LS_FREE : LS_RESV;
			lg_next[i] = (i + 1 < n) ? i + 1 : LARGE_FRAMES;
			lg_prev[i] = LARGE_FRAMES;
			lg_refs[i] = '0;
			sm_head[i] = 0;
			sm_count[i] = 0;
		end
		free_stack_top = (n > 0) ? 0 : LARGE_FRAMES;
		split_top = LARGE_FRAMES;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(int unsigned l, int unsigned s);
		longint unsigned a;
		a = ((longint'(area_base) + l) << 21) + (longint'(s) << 12);
		return a[ADDR_W-1:0];
	endfunction

	function automatic void pop_slot(int unsigned l, int unsigned s, logic [REF_W-1:0] cnt);
		int unsigned k;
		k = l * SMALL_PER_LARGE + s;
		sm_state[k] = SS_USED;
		sm_refs[k] = cnt;
		sm_head[l] = sm_next[k];
		sm_count[l] = (sm_count[l] - 1) & 10'h3FF;
	endfunction

	// The head of the split list has run out of slots: mark it full, unlink it.
	function automatic void retire_split_top(int unsigned l);
		int unsigned nx;
		nx = lg_next[l];
		lg_state[l] = LS_FULL;
		split_top = nx;
		if (nx < LARGE_FRAMES)
			lg_prev[nx] = LARGE_FRAMES;
	endfunction

	function automatic resp_t predict_alloc(bit want_small, logic [REF_W-1:0] cnt,
			output logic [ADDR_W-1:0] addr);
		int unsigned l, s, b;
		addr = '0;
		if (want_small && split_top < LARGE_FRAMES) begin
			l = split_top;
			s = sm_head[l] % SMALL_PER_LARGE;
			if (s != 0) begin
				pop_slot(l, s, cnt);
				if (sm_head[l] == 0)
					retire_split_top(l);
				addr = addr_of(l, s);
				return RS_OK;
			end
			retire_split_top(l);
		end
		l = free_stack_top;
		if (l >= LARGE_FRAMES)
			return RS_NO_MEMORY;
		free_stack_top = lg_next[l];
		if (!want_small) begin
			lg_state[l] = LS_USED;
			lg_refs[l] = cnt;
			addr = addr_of(l, 0);
			return RS_OK;
		end
		// Carve the frame into small slots; slot 0 stays off the stack.
		b = l * SMALL_PER_LARGE;
		sm_state[b] = SS_FREE;
		sm_next[b] = 0;
		for (int i = 1; i < SMALL_PER_LARGE; i++) begin
			sm_state[b + i] = SS_FREE;
			sm_refs[b + i] = '0;
			sm_next[b + i] = (i + 1 < SMALL_PER_LARGE) ? i + 1 : 0;
		end
		sm_head[l] = 1;
		sm_count[l] = SMALL_PER_LARGE - 1;
		lg_state[l] = LS_SPLIT;
		s = sm_head[l];
		pop_slot(l, s, cnt);
		lg_next[l] = split_top;
		lg_prev[l] = LARGE_FRAMES;
		if (split_top < LARGE_FRAMES)
			lg_prev[split_top] = l;
		split_top = l;
		addr = addr_of(l, s);
		return RS_OK;
	endfunction

	// Returns 1 when the frame is to be freed.
	function automatic bit refs_drop_to_free(inout logic [REF_W-1:0] refs,
			input longint delta, input bit ign, inout logic [REF_W-1:0] newc);
		longint v;
		if (delta == 0)
			return ign || refs <= 1;
		v = longint'(refs) + delta;
		if (v < 0)
			v = 0;
		if (v > longint'(REF_MAX))
			v = longint'(REF_MAX);
		refs = v[REF_W-1:0];
		newc = v[REF_W-1:0];
		return v == 0;
	endfunction

	function automatic void push_free_stack(int unsigned l);
		lg_state[l] = LS_FREE;
		lg_refs[l] = '0;
		lg_next[l] = free_stack_top;
		free_stack_top = l;
	endfunction

	function automatic resp_t predict_release(logic [ADDR_W-1:0] addr, longint delta, bit ign,
			output logic [REF_W-1:0] newc);
		longint unsigned lo, hi;
		int unsigned l, s, k, nx, pv;
		lstat_t st;
		newc = '0;
		lo = longint'(area_base) << 21;
		hi = lo + (longint'(frames_managed()) << 21);
		if (addr < lo || addr >= hi)
			return RS_RANGE;
		l = int'((addr - lo) >> 21);
		if (l >= LARGE_FRAMES)
			return RS_RANGE;
		s = int'(addr[20:12]);
		st = lg_state[l];
		if (st == LS_FREE)
			return RS_FREE;
		if (st == LS_RESV)
			return RS_RESERVED;
		if (st == LS_USED) begin
			if (refs_drop_to_free(lg_refs[l], delta, ign, newc)) begin
				push_free_stack(l);
				return RS_OK;
			end
			return (delta == 0) ? RS_IN_USE : RS_OK;
		end
		if (st != LS_SPLIT && st != LS_FULL)
			return RS_INTEGRITY;
		if (s == 0)
			return RS_RESERVED;
		k = l * SMALL_PER_LARGE + s;
		if (sm_state[k] == SS_FREE)
			return RS_FREE;
		if (sm_state[k] != SS_USED)
			return RS_RESERVED;
		if (!refs_drop_to_free(sm_refs[k], delta, ign, newc))
			return (delta == 0) ? RS_IN_USE : RS_OK;
		sm_state[k] = SS_FREE;
		sm_next[k] = sm_head[l];
		sm_head[l] = s;
		sm_count[l] = (sm_count[l] + 1) & 10'h3FF;
		if (st == LS_FULL) begin
			// A full frame that regains a slot goes back on top of the split list.
			lg_state[l] = LS_SPLIT;
			lg_next[l] = split_top;
			if (split_top < LARGE_FRAMES)
				lg_prev[split_top] = l;
			split_top = l;
			lg_prev[l] = LARGE_FRAMES;
		end else if (sm_count[l] == SMALL_PER_LARGE - 1) begin
			// Every slot is free again: unlink and hand the whole frame back.
			nx = lg_next[l];
			pv = lg_prev[l];
			if (nx < LARGE_FRAMES)
				lg_prev[nx] = pv;
			if (pv < LARGE_FRAMES)
				lg_next[pv] = nx;
			if (split_top == l)
				split_top = nx;
			lg_prev[l] = LARGE_FRAMES;
			push_free_stack(l);
		end
		return RS_OK;
	endfunction

	// Predicts a request against the shadow state and queues it for the driver.
	task automatic queue_request(input logic [1:0] rt, input logic [ADDR_W-1:0] a,
			input logic [REF_W-1:0] cnt, input logic signed [31:0] d, input logic ign,
			output request_s r);
		logic [ADDR_W-1:0] got;
		logic [REF_W-1:0] nc;
		r.rtype = rt;
		r.addr = a;
		r.cnt = cnt;
		r.delta = d;
		r.ign = ign;
		got = '0;
		nc = '0;
		case (rt)
			REQ_ALLOC_SMALL: r.want_status = predict_alloc(1'b1, cnt, got);
			REQ_ALLOC_LARGE: r.want_status = predict_alloc(1'b0, cnt, got);
			REQ_RELEASE: r.want_status = predict_release(a, longint'(d), ign, nc);
			default: r.want_status = RS_RANGE;
		endcase
		r.want_addr = got;
		r.want_count = nc;
		waiting_reqs.push_back(r);
		if (rt != REQ_RELEASE && r.want_status == RS_OK)
			live_frames.push_back(got);
	endtask

	function automatic logic [REF_W-1:0] pick_count();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_delta();
		case ($urandom_range(11))
			0: return 32'sd1;
			1: return -32'sd1;
			2: return $urandom;
			3: return 32'sh7FFFFFFF;
			4: return 32'sh80000000;
			5: return $urandom_range(1, 4);
			default: return 32'sd0;
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] addr_in_area();
		return addr_of($urandom_range(frames_managed()), $urandom_range(SMALL_PER_LARGE - 1));
	endfunction

	task automatic queue_random_request();
		request_s r;
		int pick, idx;
		logic signed [31:0] d;
		logic [ADDR_W-1:0] a;
		pick = $urandom_range(99);
		if (pick < 40) begin
			queue_request(REQ_ALLOC_SMALL, ADDR_W'({$urandom, $urandom}), pick_count(),
				$urandom, 1'($urandom_range(1)), r);
		end else if (pick < 55) begin
			queue_request(REQ_ALLOC_LARGE, ADDR_W'({$urandom, $urandom}), pick_count(),
				$urandom, 1'($urandom_range(1)), r);
		end else if (pick < 90 && live_frames.size() > 0) begin
			idx = $urandom_range(live_frames.size() - 1);
			d = pick_delta();
			queue_request(REQ_RELEASE, live_frames[idx], $urandom, d,
				$urandom_range(3) == 0, r);
			if (r.want_status == RS_OK && (d == 0 || r.want_count == 0))
				live_frames.delete(idx);
		end else if (pick < 96) begin
			a = ($urandom_range(1)) ? addr_in_area() : ADDR_W'({$urandom, $urandom});
			queue_request(REQ_RELEASE, a, $urandom, pick_delta(), 1'($urandom_range(1)), r);
		end else begin
			queue_request(REQ_BAD, ADDR_W'({$urandom, $urandom}), $urandom, $urandom,
				1'($urandom_range(1)), r);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Request driver: the head of the waiting queue is offered, with random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_results.push_back(waiting_reqs.pop_front());
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (waiting_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				req_type <= waiting_reqs[0].rtype;
				frame_addr <= waiting_reqs[0].addr;
				ref_count <= waiting_reqs[0].cnt;
				ref_delta <= waiting_reqs[0].delta;
				ignore_refs <= waiting_reqs[0].ign;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver stalls; a requested hold-off keeps ready low
	// for a long stretch while the driver keeps offering.
	int hold_left = 0;
	int hold_seen = 0;
	always @(posedge clk) begin
		request_s w;
		if (out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result addr", result_addr, 0);
			end else begin
				w = awaited_results.pop_front();
				if (result_addr !== w.want_addr)
					report_mismatch("result_addr", result_addr, w.want_addr);
				if (status !== w.want_status)
					report_mismatch("status", status, w.want_status);
				if (new_ref_count !== w.want_count)
					report_mismatch("new_ref_count", new_ref_count, w.want_count);
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= hold_len;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_two_level_page_frame_allocator_core: errors");
			$finish;
		end
	end

	task automatic drain();
		while (waiting_reqs.size() > 0 || awaited_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Both registers are written; each write reruns the rebuild pass.
	task automatic set_area(input logic [BASE_W-1:0] b, input logic [NCFG_W-1:0] n);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_wdata <= b;
		@(posedge clk);
		cfg_index <= CFG_COUNT;
		cfg_wdata <= BASE_W'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		area_base = b;
		area_count = n;
		rebuild_area();
	endtask

	task automatic random_phase(input int items, input int sidle, input int rstall,
			input int hold);
		sender_idle_pct = sidle;
		recv_stall_pct = rstall;
		if (hold > 0) begin
			hold_len = hold;
			hold_seq++;
		end
		repeat (items) queue_random_request();
		drain();
	endtask

	initial begin
		request_s r, s1, s2, lg1, lg2, sm;
		area_base = '0;
		area_count = LARGE_FRAMES;
		rebuild_area();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening on the reset area.
		queue_request(REQ_ALLOC_SMALL, '0, '0, '0, 1'b0, s1);
		queue_request(REQ_ALLOC_SMALL, '1, '1, '1, 1'b1, s2);
		queue_request(REQ_ALLOC_LARGE, '0, 32'd1, '0, 1'b0, lg1);
		queue_request(REQ_ALLOC_LARGE, '0, 32'd3, '0, 1'b0, lg2);
		// Slot zero of a split frame, a free frame, past the end, bad type.
		queue_request(REQ_RELEASE, addr_of(0, 0), '0, '0, 1'b0, r);
		queue_request(REQ_RELEASE, addr_of(3, 0), '0, '0, 1'b0, r);
		queue_request(REQ_RELEASE, addr_of(LARGE_FRAMES, 0), '0, '0, 1'b0, r);
		queue_request(REQ_BAD, '1, '1, '1, 1'b1, r);
		// Counts: still in use, saturate upward, saturate to zero and free.
		queue_request(REQ_RELEASE, lg2.want_addr, '0, '0, 1'b0, r);
		queue_request(REQ_RELEASE, lg2.want_addr, '0, 32'sh7FFFFFFF, 1'b0, r);
		queue_request(REQ_RELEASE, lg2.want_addr, '0, 32'sh7FFFFFFF, 1'b0, r);
		queue_request(REQ_RELEASE, lg2.want_addr, '0, 32'sh80000000, 1'b0, r);
		queue_request(REQ_RELEASE, lg2.want_addr, '0, 32'sh80000000, 1'b0, r);
		queue_request(REQ_RELEASE, lg1.want_addr, '0, '0, 1'b0, r);
		// Free both small frames; the split frame returns whole.
		queue_request(REQ_RELEASE, s1.want_addr, '0, '0, 1'b0, r);
		queue_request(REQ_RELEASE, s2.want_addr, '0, '0, 1'b1, r);
		queue_request(REQ_RELEASE, s2.want_addr, '0, '0, 1'b0, r);
		queue_request(REQ_ALLOC_SMALL, '0, '1, '0, 1'b0, sm);
		queue_request(REQ_RELEASE, sm.want_addr, '0, -32'sd1, 1'b0, r);
		queue_request(REQ_RELEASE, sm.want_addr, '0, 32'sd5, 1'b0, r);
		queue_request(REQ_RELEASE, sm.want_addr, '0, '0, 1'b1, r);
		live_frames.delete();
		drain();
		random_phase(40, 0, 0, 0);

		// Widest base: addresses wrap at the top of the address space.
		live_frames.delete();
		set_area('1, 7'd64);
		random_phase(40, 67, 0, 0);

		// One frame, filled until every slot is taken and memory runs out.
		live_frames.delete();
		set_area(27'd9, 7'd1);
		sender_idle_pct = 0;
		recv_stall_pct = 33;
		repeat (SMALL_PER_LARGE) queue_request(REQ_ALLOC_SMALL, '0, pick_count(), '0, 1'b0, r);
		queue_request(REQ_ALLOC_LARGE, '0, 32'd1, '0, 1'b0, r);
		repeat (30) queue_random_request();
		drain();

		// Two frames behind a long receiver hold-off.
		live_frames.delete();
		set_area(BASE_W'($urandom), 7'd2);
		random_phase(40, 0, 67, 400);

		// Empty area.
		live_frames.delete();
		set_area('0, 7'd0);
		random_phase(20, 33, 33, 0);

		// Count beyond the frame memory saturates.
		live_frames.delete();
		set_area(27'd123, 7'd127);
		random_phase(30, 33, 33, 0);

		live_frames.delete();
		set_area(BASE_W'($urandom), 7'd3);
		random_phase(30, 0, 0, 0);

		if (errors == 0)
			$display("tb_two_level_page_frame_allocator_core: clean");
		else
			$display("tb_two_level_page_frame_allocator_core: errors");
		$finish;
	end

endmodule

// File: filelist.f
design/tlpfa_pkg.sv
design/tlpfa_ram.sv
design/two_level_page_frame_allocator_core.sv
design/tlpfa_checker.sv
dv/tb_two_level_page_frame_allocator_core.sv
